@@ hw/rtl/jacs_pkg.sv @@
// Shared types and constants of the joystick axis calibrated scaler.
// No dependencies; the front end, queue, back end and top level refer to this package.
package jacs_pkg;

	// request codes
	localparam logic [1:0] REQ_EVENT     = 2'd0;
	localparam logic [1:0] REQ_CAL_START = 2'd1;
	localparam logic [1:0] REQ_CAL_END   = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_TOP_X = 2'd0;
	localparam logic [1:0] CFG_TOP_Y = 2'd1;
	localparam logic [1:0] CFG_TOP_Z = 2'd2;
	localparam logic [1:0] CFG_PLAIN = 2'd3;

	// axis numbers of the event stream
	localparam logic [7:0] AXIS_X = 8'd0;
	localparam logic [7:0] AXIS_Y = 8'd1;
	localparam logic [7:0] AXIS_Z = 8'd2;

	// raw positions span +-RAW_FULL_SCALE
	localparam int RAW_SHIFT      = 7;
	localparam int RAW_FULL_SCALE = 1 << RAW_SHIFT;
	localparam int RAW_HALF       = RAW_FULL_SCALE / 2;
	localparam int RAW_W          = RAW_SHIFT + 2;

	// event values span +-EV_FULL
	localparam int EV_SHIFT = 15;
	localparam int EV_FULL  = (1 << EV_SHIFT) - 1;
	localparam int EV_HALF  = EV_FULL / 2;

	// speed widths and saturation
	localparam int TOP_W     = 15;
	localparam int OUT_W     = 16;
	localparam int MASK_W    = 16;
	localparam int OUT_LIMIT = (1 << TOP_W) - 1;

	typedef logic signed [RAW_W-1:0] raw_t;

	// configuration seen by the back end
	typedef struct packed {
		logic [TOP_W-1:0] top_x;
		logic [TOP_W-1:0] top_y;
		logic [TOP_W-1:0] top_z;
		logic             plain;
	} cfg_t;

	// snapshot of the tracking state after one request
	typedef struct packed {
		raw_t              raw_x;
		raw_t              raw_y;
		raw_t              raw_z;
		raw_t              center_x;
		raw_t              center_y;
		raw_t              highest_x;
		raw_t              lowest_x;
		raw_t              highest_y;
		raw_t              lowest_y;
		logic [MASK_W-1:0] buttons;
	} job_t;

endpackage

@@ hw/rtl/jacs_req_if.sv @@
// Request channel of the joystick scaler: valid/ready plus the event word.
// Stand-alone interface, no package needed.
interface jacs_req_if;
	logic              valid;
	logic              ready;
	logic [1:0]        req_type;
	logic              event_is_axis;
	logic              event_is_button;
	logic [7:0]        event_number;
	logic signed [15:0] event_value;

	modport source (
		output valid, req_type, event_is_axis, event_is_button, event_number, event_value,
		input  ready
	);
	modport sink (
		input  valid, req_type, event_is_axis, event_is_button, event_number, event_value,
		output ready
	);
endinterface

@@ hw/rtl/jacs_rsp_if.sv @@
// Result channel of the joystick scaler: valid/ready plus the speed word.
// Stand-alone interface, no package needed.
interface jacs_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] adjusted_x;
	logic signed [15:0] adjusted_y;
	logic signed [15:0] adjusted_z;
	logic [15:0]        button_mask;

	modport source (
		output valid, adjusted_x, adjusted_y, adjusted_z, button_mask,
		input  ready
	);
	modport sink (
		input  valid, adjusted_x, adjusted_y, adjusted_z, button_mask,
		output ready
	);
endinterface

@@ hw/rtl/jacs_front.sv @@
// Front end: accepts request words, scales axis values, tracks extremes,
// centers and buttons, and pushes a state snapshot. Uses jacs_pkg, jacs_req_if.
module jacs_front #(
	parameter int BUTTON_COUNT = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	jacs_req_if.sink          req,
	output logic              push,
	input  logic              push_ready,
	output jacs_pkg::job_t    push_job
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_UPD  = 2'd1;
	localparam logic [1:0] ST_PUSH = 2'd2;
	localparam int MW = 17 + jacs_pkg::RAW_SHIFT;

	logic [1:0] state_q;

	logic [1:0]         req_type_s1;
	logic               is_axis_s1;
	logic               is_button_s1;
	logic [7:0]         number_s1;
	logic signed [15:0] value_s1;

	jacs_pkg::raw_t raw_x_q, raw_y_q, raw_z_q;
	jacs_pkg::raw_t hi_x_q, lo_x_q, hi_y_q, lo_y_q;
	jacs_pkg::raw_t cen_x_q, cen_y_q;
	logic [BUTTON_COUNT-1:0] pressed_q;
	logic [BUTTON_COUNT-1:0] pressed_nx;

	logic signed [16:0] val_ext;
	logic               val_neg;
	logic [16:0]        val_mag;
	logic [MW-1:0]      scaled;
	logic [8:0]         q0;
	logic [16:0]        rem;
	logic [8:0]         q_mag;
	jacs_pkg::raw_t     raw_pos;
	jacs_pkg::raw_t     raw_neg;

	logic           widen;
	jacs_pkg::raw_t hi_x_nx, lo_x_nx, hi_y_nx, lo_y_nx;
	logic [jacs_pkg::MASK_W-1:0] btn_view;

	assign req.ready = (state_q == ST_IDLE);

	// round(|v| * full / 32767): split off the top bits, fold them back, correct once
	always_comb begin
		val_ext = {value_s1[15], value_s1};
		val_neg = value_s1[15];
		val_mag = val_neg ? 17'(-val_ext) : 17'(val_ext);
		scaled  = (MW'(val_mag) << jacs_pkg::RAW_SHIFT) + MW'(jacs_pkg::EV_HALF);
		q0      = 9'(scaled >> jacs_pkg::EV_SHIFT);
		rem     = 17'(scaled[jacs_pkg::EV_SHIFT-1:0]) + 17'(q0);
		q_mag   = (rem >= 17'(jacs_pkg::EV_FULL)) ? q0 + 9'd1 : q0;
		raw_pos = jacs_pkg::raw_t'(q_mag);
		raw_neg = -raw_pos;
	end

	// next button bits, one compare per bit
	for (genvar i = 0; i < BUTTON_COUNT; i++) begin : g_btn
		assign pressed_nx[i] = (is_button_s1 && number_s1 == 8'(i)) ?
			(value_s1 != 16'sd0) : pressed_q[i];
	end

	// low bits of the pressed mask, zero above the button count
	for (genvar i = 0; i < jacs_pkg::MASK_W; i++) begin : g_view
		if (i < BUTTON_COUNT) begin : g_on
			assign btn_view[i] = pressed_q[i];
		end else begin : g_off
			assign btn_view[i] = 1'b0;
		end
	end

	// widen extremes after an axis event
	always_comb begin
		widen   = (req_type_s1 == jacs_pkg::REQ_EVENT) && is_axis_s1;
		hi_x_nx = (widen && raw_x_q > hi_x_q) ? raw_x_q : hi_x_q;
		lo_x_nx = (widen && raw_x_q < lo_x_q) ? raw_x_q : lo_x_q;
		hi_y_nx = (widen && raw_y_q > hi_y_q) ? raw_y_q : hi_y_q;
		lo_y_nx = (widen && raw_y_q < lo_y_q) ? raw_y_q : lo_y_q;
	end

	assign push = (state_q == ST_PUSH);

	always_comb begin
		push_job.raw_x     = raw_x_q;
		push_job.raw_y     = raw_y_q;
		push_job.raw_z     = raw_z_q;
		push_job.center_x  = cen_x_q;
		push_job.center_y  = cen_y_q;
		push_job.highest_x = hi_x_nx;
		push_job.lowest_x  = lo_x_nx;
		push_job.highest_y = hi_y_nx;
		push_job.lowest_y  = lo_y_nx;
		push_job.buttons   = btn_view;
	end

	// capture the accepted word
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_type_s1  <= req.req_type;
			is_axis_s1   <= req.event_is_axis;
			is_button_s1 <= req.event_is_button;
			number_s1    <= req.event_number;
			value_s1     <= req.event_value;
		end
	end

	// sequence: take word, apply update, push snapshot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			raw_x_q   <= '0;
			raw_y_q   <= '0;
			raw_z_q   <= '0;
			hi_x_q    <= '0;
			lo_x_q    <= '0;
			hi_y_q    <= '0;
			lo_y_q    <= '0;
			cen_x_q   <= '0;
			cen_y_q   <= '0;
			pressed_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req.valid) state_q <= ST_UPD;
				end
				ST_UPD: begin
					unique case (req_type_s1)
						jacs_pkg::REQ_EVENT: begin
							pressed_q <= pressed_nx;
							if (is_axis_s1) begin
								if (number_s1 == jacs_pkg::AXIS_X)
									raw_x_q <= val_neg ? raw_neg : raw_pos;
								else if (number_s1 == jacs_pkg::AXIS_Y)
									raw_y_q <= val_neg ? raw_pos : raw_neg;
								else if (number_s1 == jacs_pkg::AXIS_Z)
									raw_z_q <= val_neg ? raw_pos : raw_neg;
							end
						end
						jacs_pkg::REQ_CAL_START: begin
							hi_x_q  <= raw_x_q;
							lo_x_q  <= raw_x_q;
							cen_x_q <= raw_x_q;
							hi_y_q  <= raw_y_q;
							lo_y_q  <= raw_y_q;
							cen_y_q <= raw_y_q;
						end
						jacs_pkg::REQ_CAL_END: begin
							cen_x_q <= raw_x_q;
							cen_y_q <= raw_y_q;
						end
						default: begin
						end
					endcase
					state_q <= ST_PUSH;
				end
				ST_PUSH: begin
					if (push_ready) begin
						hi_x_q  <= hi_x_nx;
						lo_x_q  <= lo_x_nx;
						hi_y_q  <= hi_y_nx;
						lo_y_q  <= lo_y_nx;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// between requests the extremes bracket both the position and the center
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (lo_x_q <= raw_x_q && raw_x_q <= hi_x_q &&
			lo_x_q <= cen_x_q && cen_x_q <= hi_x_q))
		else $error("x extremes do not bracket position and center");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (lo_y_q <= raw_y_q && raw_y_q <= hi_y_q &&
			lo_y_q <= cen_y_q && cen_y_q <= hi_y_q))
		else $error("y extremes do not bracket position and center");

	assert property (@(posedge clk) disable iff (!arst_n)
		(raw_z_q <= jacs_pkg::raw_t'(jacs_pkg::RAW_FULL_SCALE) &&
			raw_z_q >= -jacs_pkg::raw_t'(jacs_pkg::RAW_FULL_SCALE)))
		else $error("raw z outside full scale");

endmodule

@@ hw/rtl/jacs_fifo.sv @@
// Two-entry snapshot queue between front and back end of the joystick scaler.
// Uses jacs_pkg::job_t.
module jacs_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           push_ready,
	input  jacs_pkg::job_t push_job,
	input  logic           pop,
	output logic           pop_valid,
	output jacs_pkg::job_t pop_job
);

	jacs_pkg::job_t entry_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;
	logic           do_push;
	logic           do_pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_job    = entry_q[rd_ptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && pop_valid;

	// store the word at the write pointer
	always_ff @(posedge clk) begin
		if (do_push) entry_q[wr_ptr_q] <= push_job;
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= ~wr_ptr_q;
			if (do_pop) rd_ptr_q <= ~rd_ptr_q;
			if (do_push && !do_pop) count_q <= count_q + 2'd1;
			else if (do_pop && !do_push) count_q <= count_q - 2'd1;
		end
	end

endmodule

@@ hw/rtl/jacs_back.sv @@
// Back end: turns a state snapshot into x, y and z speeds with one shared
// multiplier and a radix-2 divider, and holds the result word. Uses jacs_pkg, jacs_rsp_if.
module jacs_back (
	input  logic           clk,
	input  logic           arst_n,
	input  jacs_pkg::cfg_t cfg,
	output logic           pop,
	input  logic           pop_valid,
	input  jacs_pkg::job_t pop_job,
	jacs_rsp_if.source     rsp
);

	localparam logic [2:0] B_IDLE = 3'd0;
	localparam logic [2:0] B_MUL  = 3'd1;
	localparam logic [2:0] B_CHK  = 3'd2;
	localparam logic [2:0] B_DIV  = 3'd3;
	localparam logic [2:0] B_FIN  = 3'd4;
	localparam logic [2:0] B_OUT  = 3'd5;

	localparam logic [1:0] AX_X = 2'd0;
	localparam logic [1:0] AX_Y = 2'd1;
	localparam logic [1:0] AX_Z = 2'd2;

	localparam int TW = jacs_pkg::TOP_W;
	localparam int RW = jacs_pkg::RAW_W;
	localparam int PW = RW + TW;

	logic [2:0]     state_q;
	logic [1:0]     axis_q;
	jacs_pkg::job_t job_q;

	logic [PW-1:0] prod_q;
	logic [RW-1:0] den_q;
	logic          neg_q;
	logic          zero_q;
	logic          plain_q;
	logic          ovf_q;
	logic [RW-1:0] rem_q;
	logic [TW-1:0] dvd_q;
	logic [3:0]    cnt_q;

	logic signed [jacs_pkg::OUT_W-1:0] res_x_q, res_y_q, res_z_q;

	logic                        out_valid_q;
	logic signed [jacs_pkg::OUT_W-1:0] out_x_q, out_y_q, out_z_q;
	logic [jacs_pkg::MASK_W-1:0] out_btn_q;

	jacs_pkg::raw_t   raw_sel, cen_sel, hi_sel, lo_sel;
	logic [TW-1:0]    top_sel;
	logic             plain_sel;
	logic signed [RW:0] d_up, d_dn, den_up, den_dn, raw_ext;
	logic [RW-1:0]    mag_sel;
	logic [RW-1:0]    den_sel;
	logic             neg_sel;
	logic             zero_sel;
	logic [PW-1:0]    prod_sel;

	logic [RW:0]      trial;
	logic             trial_ge;
	logic [PW-1:0]    rounded;
	logic [PW-1:0]    plain_mag;
	logic [TW-1:0]    fin_mag;
	logic [jacs_pkg::OUT_W-1:0] fin_val;
	logic             out_free;

	// pick the operands of the current axis
	always_comb begin
		raw_sel   = job_q.raw_z;
		cen_sel   = '0;
		hi_sel    = '0;
		lo_sel    = '0;
		top_sel   = cfg.top_z;
		plain_sel = 1'b1;
		unique case (axis_q)
			AX_X: begin
				raw_sel   = job_q.raw_x;
				cen_sel   = job_q.center_x;
				hi_sel    = job_q.highest_x;
				lo_sel    = job_q.lowest_x;
				top_sel   = cfg.top_x;
				plain_sel = cfg.plain;
			end
			AX_Y: begin
				raw_sel   = job_q.raw_y;
				cen_sel   = job_q.center_y;
				hi_sel    = job_q.highest_y;
				lo_sel    = job_q.lowest_y;
				top_sel   = cfg.top_y;
				plain_sel = cfg.plain;
			end
			default: begin
			end
		endcase
	end

	// classify: plain magnitude, deflection above or below the center, or none
	always_comb begin
		raw_ext = {raw_sel[RW-1], raw_sel};
		d_up    = raw_ext - {cen_sel[RW-1], cen_sel};
		d_dn    = {cen_sel[RW-1], cen_sel} - raw_ext;
		den_up  = {hi_sel[RW-1], hi_sel} - {cen_sel[RW-1], cen_sel};
		den_dn  = {cen_sel[RW-1], cen_sel} - {lo_sel[RW-1], lo_sel};
		mag_sel  = '0;
		den_sel  = '0;
		neg_sel  = 1'b0;
		zero_sel = 1'b0;
		if (plain_sel) begin
			mag_sel = raw_sel[RW-1] ? RW'(-raw_ext) : RW'(raw_ext);
			neg_sel = raw_sel[RW-1];
		end else if (raw_sel > cen_sel && hi_sel != cen_sel) begin
			mag_sel = RW'(d_up);
			den_sel = RW'(den_up);
		end else if (raw_sel <= cen_sel && cen_sel != lo_sel) begin
			mag_sel = RW'(d_dn);
			den_sel = RW'(den_dn);
			neg_sel = 1'b1;
		end else begin
			zero_sel = 1'b1;
		end
		prod_sel = PW'(mag_sel) * PW'(top_sel);
	end

	// one restoring divide step
	always_comb begin
		trial    = {rem_q, dvd_q[TW-1]};
		trial_ge = (trial >= {1'b0, den_q});
	end

	// final magnitude, saturated, and its sign
	always_comb begin
		rounded   = prod_q + PW'(jacs_pkg::RAW_HALF);
		plain_mag = rounded >> jacs_pkg::RAW_SHIFT;
		if (plain_q)
			fin_mag = (plain_mag > PW'(jacs_pkg::OUT_LIMIT)) ? TW'(jacs_pkg::OUT_LIMIT)
				: plain_mag[TW-1:0];
		else if (zero_q)
			fin_mag = '0;
		else if (ovf_q)
			fin_mag = TW'(jacs_pkg::OUT_LIMIT);
		else
			fin_mag = dvd_q;
		fin_val = neg_q ? (jacs_pkg::OUT_W'(0) - {1'b0, fin_mag}) : {1'b0, fin_mag};
	end

	assign out_free = !out_valid_q || rsp.ready;
	assign pop      = (state_q == B_IDLE);

	// snapshot and working registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			B_IDLE: begin
				if (pop_valid) job_q <= pop_job;
			end
			B_MUL: begin
				prod_q  <= prod_sel;
				den_q   <= den_sel;
				neg_q   <= neg_sel;
				zero_q  <= zero_sel;
				plain_q <= plain_sel;
			end
			B_CHK: begin
				ovf_q <= (prod_q[PW-1:TW] >= den_q);
				rem_q <= prod_q[PW-1:TW];
				dvd_q <= prod_q[TW-1:0];
			end
			B_DIV: begin
				rem_q <= trial_ge ? RW'(trial - {1'b0, den_q}) : trial[RW-1:0];
				dvd_q <= {dvd_q[TW-2:0], trial_ge};
			end
			B_FIN: begin
				unique case (axis_q)
					AX_X: res_x_q <= fin_val;
					AX_Y: res_y_q <= fin_val;
					default: res_z_q <= fin_val;
				endcase
			end
			default: begin
			end
		endcase
	end

	// sequence the three axes and the hand-off to the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			axis_q  <= AX_X;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				B_IDLE: begin
					if (pop_valid) begin
						axis_q  <= AX_X;
						state_q <= B_MUL;
					end
				end
				B_MUL: begin
					state_q <= (plain_sel || zero_sel) ? B_FIN : B_CHK;
				end
				B_CHK: begin
					cnt_q   <= '0;
					state_q <= (prod_q[PW-1:TW] >= den_q) ? B_FIN : B_DIV;
				end
				B_DIV: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'(TW - 1)) state_q <= B_FIN;
				end
				B_FIN: begin
					unique case (axis_q)
						AX_X: begin
							axis_q  <= AX_Y;
							state_q <= B_MUL;
						end
						AX_Y: begin
							axis_q  <= AX_Z;
							state_q <= B_MUL;
						end
						default: state_q <= B_OUT;
					endcase
				end
				B_OUT: begin
					if (out_free) state_q <= B_IDLE;
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	// output word: load when free, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == B_OUT && out_free) out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == B_OUT && out_free) begin
			out_x_q   <= res_x_q;
			out_y_q   <= res_y_q;
			out_z_q   <= res_z_q;
			out_btn_q <= job_q.buttons;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.adjusted_x  = out_x_q;
	assign rsp.adjusted_y  = out_y_q;
	assign rsp.adjusted_z  = out_z_q;
	assign rsp.button_mask = out_btn_q;

endmodule

@@ hw/rtl/joystick_axis_calibrated_scaler_unit.sv @@
// Joystick axis calibrated scaler: top level with configuration registers.
// Uses jacs_pkg, jacs_req_if, jacs_rsp_if, jacs_front, jacs_fifo, jacs_back.
//
// Usage
//   req carries one word per request: a joystick event (button and/or axis),
//   a start-calibration or an end-calibration command. rsp returns exactly one
//   word per request with the x, y and z speeds and the pressed-button mask.
//   cfg_write_en/cfg_index/cfg_data write top speeds and the plain mode; write
//   them only while no request is in flight.
// Processing steps
//   The front end takes a word, applies the update and pushes its snapshot
//   once the queue has room, and only then takes the next word. The back end
//   works through x, y and z in turn: a calibrated x or y axis takes multiply,
//   range check, 15 divide steps of the shared radix-2 divider and sign; a plain
//   or centered axis takes multiply and sign, and a saturating quotient skips the
//   divide steps. The result word is then handed off before the next snapshot.
// Reset and stalls
//   arst_n clears positions, extremes, centers, buttons, configuration and control
//   registers to zero. A stalled rsp holds its word; the back end finishes the next
//   word, the two-entry queue fills and the front end holds one more, req.ready low.
module joystick_axis_calibrated_scaler_unit #(
	parameter int BUTTON_COUNT = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_write_en,
	input  logic [1:0]                  cfg_index,
	input  logic [jacs_pkg::TOP_W-1:0]  cfg_data,
	jacs_req_if.sink                    req,
	jacs_rsp_if.source                  rsp
);

	jacs_pkg::cfg_t cfg_q;
	logic           push;
	logic           push_ready;
	jacs_pkg::job_t push_job;
	logic           pop;
	logic           pop_valid;
	jacs_pkg::job_t pop_job;

	// configuration register decode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				jacs_pkg::CFG_TOP_X: cfg_q.top_x <= cfg_data;
				jacs_pkg::CFG_TOP_Y: cfg_q.top_y <= cfg_data;
				jacs_pkg::CFG_TOP_Z: cfg_q.top_z <= cfg_data;
				jacs_pkg::CFG_PLAIN: cfg_q.plain <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	jacs_front #(
		.BUTTON_COUNT(BUTTON_COUNT)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.push       (push),
		.push_ready (push_ready),
		.push_job   (push_job)
	);

	jacs_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ready (push_ready),
		.push_job   (push_job),
		.pop        (pop),
		.pop_valid  (pop_valid),
		.pop_job    (pop_job)
	);

	jacs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pop       (pop),
		.pop_valid (pop_valid),
		.pop_job   (pop_job),
		.rsp       (rsp)
	);

endmodule
